// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define PFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Property checked on every clock edge, reset included.
`define PFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/pfsma_pkg.sv =====
`timescale 1ns / 1ps

package pfsma_pkg;

  localparam int COUNT_W  = 14;   // bridge count and calibration counts
  localparam int RATE_W   = 10;   // rated range register
  localparam int DIV_W    = 14;   // divisor magnitude
  localparam int PROD_W   = COUNT_W + RATE_W;
  localparam int NUM_W    = 31;   // dividend magnitude, |d| * rated * 100
  localparam int DCNT_W   = $clog2(NUM_W);
  localparam int RAW_W    = 11;
  localparam int TEMP_W   = 12;
  localparam int TPROD_W  = 22;
  localparam int PRES_W   = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] ZERO_RST  = 14'd1638;
  localparam logic [COUNT_W-1:0] FULL_RST  = 14'd14745;
  localparam logic [RATE_W-1:0]  RATED_RST = 10'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_ZERO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_FULL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATED      = 2'd2;

  localparam logic ACT_FRAME = 1'b0;
  localparam logic ACT_READ  = 1'b1;
  localparam logic [1:0] STATUS_OK = 2'd0;

  localparam logic [NUM_W-1:0]   PCT_SCALE  = 31'd100;
  localparam logic [NUM_W-1:0]   OFFSET_PCT = 31'd100;
  localparam logic [NUM_W-1:0]   SAT_LIMIT  = 31'd65635;   // 65535 + offset
  localparam logic [TPROD_W-1:0] TEMP_SCALE = 22'd2000;
  localparam logic [RAW_W:0]     TEMP_DIV   = 12'd2047;
  localparam logic [TEMP_W-1:0]  TEMP_BIAS  = 12'd500;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_SCALE,
    ST_START,
    ST_DIV,
    ST_FIN
  } pfsma_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== sv/pfsma_div.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pfsma_div
  import pfsma_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [NUM_W-1:0] quotient
);

  logic             busy_r;
  logic             done_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] dsr_r;

  logic [DIV_W:0]   sh;
  logic [DIV_W+1:0] diff;
  logic             qbit;

  // One quotient bit per cycle: shift in the next dividend bit, trial subtract.
  assign sh   = {rem_r, quo_r[NUM_W-1]};
  assign diff = {1'b0, sh} - {2'b00, dsr_r};
  assign qbit = !diff[DIV_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(NUM_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= qbit ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], qbit};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

  `PFS_ASSERT(a_div_starts, start && !busy_r |=> busy_r, "divider did not start")
  `PFS_ASSERT(a_div_ends, busy_r && cnt_r == '0 |=> done_r && !busy_r, "divider did not end")
  `PFS_ASSERT_ALWAYS(a_div_rst, !rst_n |=> !busy_r && !done_r, "divider active after reset")

endmodule

// ===== sv/pressure_frame_scaler_moving_average.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Bridge pressure sensor frame decoder with a moving average over WINDOW
// samples. A frame request (in_tuser = 0) decodes status, 14-bit count and
// temperature; a frame with status zero is scaled to pressure * 100 and
// enters the window. A read request (in_tuser = 1) returns the window sum
// divided by WINDOW and clears the window and the sum; the write position
// is kept. Every request goes through the shared bit-serial divider, which
// produces one quotient bit per cycle over 31 bits. The next request is
// accepted once the result has moved to the output register, even if it
// is not yet taken. Calibration registers must be written only while idle;
// the block itself does not enforce it.

module pressure_frame_scaler_moving_average
  import pfsma_pkg::*;
#(
  parameter int WINDOW = 50
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]   cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [7:0] frame_byte0, [15:8] frame_byte1, [23:16] frame_byte2, [31:24] frame_byte3
  input  logic [31:0]          in_tdata,
  // [0] action
  input  logic                 in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [15:0] average_pressure, [31:16] sample_pressure, [43:32] temperature_tenths,
  // [45:44] sensor_status, [46] sample_taken, [47] zero
  output logic [47:0]          out_tdata
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam int SUM_W = PRES_W + $clog2(WINDOW);

  pfsma_state_t state_r, state_nxt;

  logic [COUNT_W-1:0] zero_r, full_r;
  logic [RATE_W-1:0]  rated_r;

  logic               act_r;
  logic [1:0]         status_r;
  logic [COUNT_W-1:0] count_r;
  logic [RAW_W-1:0]   raw_r;
  logic [TEMP_W-1:0]  temp_r;
  logic [DIV_W-1:0]   dmag_r, smag_r;
  logic               neg_r, szero_r;
  logic [PROD_W-1:0]  prod_r;
  logic [NUM_W-1:0]   num_r;

  logic [SUM_W-1:0]   sum_r;
  logic [IDX_W-1:0]   idx_r;
  logic [WINDOW-1:0]  valid_r;
  logic [PRES_W-1:0]  mem [WINDOW];
  logic [PRES_W-1:0]  mem_q_r;

  logic               out_valid_r;
  logic [PRES_W-1:0]  avg_r, samp_r;
  logic [TEMP_W-1:0]  temp_out_r;
  logic [1:0]         stat_out_r;
  logic               taken_r;

  logic               in_req, div_start, fin_go, mem_we;
  div_stat_t          dstat;
  logic [NUM_W-1:0]   quo;
  logic [NUM_W-1:0]   div_num;
  logic [DIV_W-1:0]   div_den;
  logic [PRES_W-1:0]  p_nxt, old_val;

  logic [COUNT_W:0]   d_diff, s_diff;
  logic [TPROD_W-1:0] t_prod;
  logic [RAW_W-1:0]   t_q0;
  logic [RAW_W:0]     t_r0;
  logic [RAW_W-1:0]   t_q;

  assign in_req = in_tvalid && in_tready;

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    div_start = 1'b0;
    fin_go    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = (in_tuser == ACT_READ) ? ST_START : ST_PREP;
      end
      ST_PREP:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_START;
      ST_START: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: if (dstat.done) state_nxt = ST_FIN;
      ST_FIN: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          fin_go    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r  <= ZERO_RST;
      full_r  <= FULL_RST;
      rated_r <= RATED_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_COUNT_ZERO: zero_r  <= cfg_wdata;
        CFG_COUNT_FULL: full_r  <= cfg_wdata;
        CFG_RATED:      rated_r <= cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- datapath ----------------
  assign d_diff = {1'b0, count_r} - {1'b0, zero_r};
  assign s_diff = {1'b0, full_r} - {1'b0, zero_r};

  // raw * 2000 / 2047: split at 2^11, fold the high part back, one correction
  assign t_prod = TPROD_W'(raw_r) * TEMP_SCALE;
  assign t_q0   = t_prod[TPROD_W-1:RAW_W];
  assign t_r0   = {1'b0, t_prod[RAW_W-1:0]} + {1'b0, t_q0};
  assign t_q    = (t_r0 >= TEMP_DIV) ? t_q0 + 1'b1 : t_q0;

  always_ff @(posedge clk) begin
    if (in_req) begin
      act_r    <= in_tuser;
      status_r <= in_tdata[7:6];
      count_r  <= {in_tdata[5:0], in_tdata[15:8]};
      raw_r    <= {in_tdata[23:16], in_tdata[31:29]};
    end
    if (state_r == ST_PREP) begin
      dmag_r  <= d_diff[COUNT_W] ? DIV_W'(-d_diff) : d_diff[DIV_W-1:0];
      smag_r  <= s_diff[COUNT_W] ? DIV_W'(-s_diff) : s_diff[DIV_W-1:0];
      neg_r   <= d_diff[COUNT_W] ^ s_diff[COUNT_W];
      szero_r <= (s_diff == '0);
      temp_r  <= TEMP_W'(t_q) - TEMP_BIAS;
    end
    if (state_r == ST_MUL)   prod_r <= PROD_W'(dmag_r) * PROD_W'(rated_r);
    if (state_r == ST_SCALE) num_r  <= NUM_W'(prod_r) * PCT_SCALE;
  end

  assign div_num = (act_r == ACT_READ) ? NUM_W'(sum_r) : num_r;
  assign div_den = (act_r == ACT_READ) ? DIV_W'(WINDOW) : smag_r;

  pfsma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .stat     (dstat),
    .quotient (quo)
  );

  // a negative quotient always lands below zero after the offset
  always_comb begin
    if (szero_r || neg_r || quo < OFFSET_PCT) p_nxt = '0;
    else if (quo > SAT_LIMIT)                 p_nxt = '1;
    else                                      p_nxt = PRES_W'(quo - OFFSET_PCT);
  end

  assign old_val = valid_r[idx_r] ? mem_q_r : '0;
  assign mem_we  = fin_go && (act_r == ACT_FRAME) && (status_r == STATUS_OK);

  always_ff @(posedge clk) begin
    if (mem_we) mem[idx_r] <= p_nxt;
    mem_q_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      idx_r   <= '0;
      valid_r <= '0;
    end else if (fin_go && act_r == ACT_READ) begin
      sum_r   <= '0;
      valid_r <= '0;
    end else if (mem_we) begin
      sum_r          <= sum_r - SUM_W'(old_val) + SUM_W'(p_nxt);
      valid_r[idx_r] <= 1'b1;
      idx_r          <= (idx_r == IDX_W'(WINDOW - 1)) ? '0 : idx_r + 1'b1;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n)          out_valid_r <= 1'b0;
    else if (fin_go)     out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      if (act_r == ACT_READ) begin
        avg_r      <= quo[PRES_W-1:0];
        samp_r     <= '0;
        temp_out_r <= '0;
        stat_out_r <= '0;
        taken_r    <= 1'b0;
      end else begin
        avg_r      <= '0;
        samp_r     <= (status_r == STATUS_OK) ? p_nxt : '0;
        temp_out_r <= temp_r;
        stat_out_r <= status_r;
        taken_r    <= (status_r == STATUS_OK);
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, taken_r, stat_out_r, temp_out_r, samp_r, avg_r};

  `PFS_ASSERT(a_idle_div_free, in_tready |-> !dstat.busy, "divider busy while idle")
  `PFS_ASSERT(a_done_in_div, dstat.done |-> state_r == ST_DIV, "divider done outside wait")
  `PFS_ASSERT(a_read_clears, fin_go && act_r == ACT_READ |=> sum_r == '0 && valid_r == '0,
              "read did not clear window")

endmodule
